// File: design/ookt_pkg.sv
`default_nettype none

package ookt_pkg;

  // Code word storage.
  localparam int CODE_BITS = 24;
  localparam int LEN_W     = $clog2(CODE_BITS + 1);
  localparam int IDX_W     = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
  // Wide enough for a full length plus the longest appended pattern.
  localparam int SUM_W     = $clog2(CODE_BITS + 15);

  // Field and register widths.
  localparam int BASE_W     = 10;
  localparam int UNITS_W    = 8;
  localparam int REP_W      = 4;
  localparam int DUR_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd4;

  // Register reset values.
  localparam logic [BASE_W-1:0]  BASE_TIME_RST = 10'd200;
  localparam logic [UNITS_W-1:0] SHORT_RST     = 8'd4;
  localparam logic [UNITS_W-1:0] LONG_RST      = 8'd12;
  localparam logic [UNITS_W-1:0] SYNC_RST      = 8'd128;
  localparam logic [REP_W-1:0]   REPEAT_RST    = 4'd5;

  // Command codes.
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_EXPIRY = 1'b1;

  // Switch codes.
  localparam logic [1:0] SW_OFF = 2'd0;
  localparam logic [1:0] SW_ON  = 2'd1;

  // Bit patterns appended for each selection.
  localparam int HOUSE_COUNT = 4;
  localparam int UNIT_COUNT  = 3;
  localparam int HOUSE_BITS  = 8;
  localparam int UNIT_BITS   = 14;
  localparam int SW_BITS     = 2;

  localparam logic [HOUSE_BITS-1:0] HOUSE_PAT [HOUSE_COUNT] = '{
    8'b00010101, 8'b01000101, 8'b01010001, 8'b01010100
  };
  localparam logic [UNIT_BITS-1:0] UNIT_PAT [UNIT_COUNT] = '{
    14'b00010101010101, 14'b01000101010101, 14'b01010001010101
  };
  localparam logic [SW_BITS-1:0] SW_OFF_PAT = 2'b00;
  localparam logic [SW_BITS-1:0] SW_ON_PAT  = 2'b11;

  typedef struct packed {
    logic       cmd;
    logic [2:0] house_sel;
    logic [1:0] unit_sel;
    logic [1:0] switch_sel;
  } in_item_t;

  typedef struct packed {
    logic             pin_level;
    logic [DUR_W-1:0] duration_us;
    logic             final_segment;
  } out_item_t;

endpackage

`default_nettype wire

// File: design/ookt_in_if.sv
`default_nettype none

interface ookt_in_if import ookt_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/ookt_out_if.sv
`default_nettype none

interface ookt_out_if import ookt_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/ook_remote_code_transmitter_top.sv
`default_nettype none

// Channel   Direction  Payload
// in_i      sink       cmd, house_sel, unit_sel, switch_sel
// out_o     source     pin_level, duration_us, final_segment
// cfg_*     write      five timing and repeat registers
//
// One item per cycle is taken unless a held result stalls the input stage; an
// item passes an input register and then the state update and duration
// multiply into the result register.
// Reset clears the transmitter state to idle and loads the register defaults.
// A held result stalls only items that make a result; an expiry that makes
// none moves on while the result register waits.

module ook_remote_code_transmitter_top import ookt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ookt_in_if.sink               in_i,
  ookt_out_if.source            out_o
);

  // Configuration registers.
  logic [BASE_W-1:0]  base_time_q;
  logic [UNITS_W-1:0] short_q, long_q, sync_q;
  logic [REP_W-1:0]   repeat_q;

  // Transmitter state.
  logic [CODE_BITS-1:0] code_word_q, code_word_d;
  logic [LEN_W-1:0]     code_len_q, code_len_d;
  logic [LEN_W-1:0]     bit_idx_q, bit_idx_d;
  logic                 half_q, half_d;
  logic [REP_W-1:0]     frames_q, frames_d;

  // Input stage and result register.
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  logic               produce;
  logic               s1_adv;
  logic               level;
  logic               fin;
  logic [UNITS_W-1:0] units;
  logic [IDX_W-1:0]   cur_idx;
  logic               cur_bit;
  logic [CODE_BITS-1:0] new_word;
  logic [LEN_W-1:0]     new_len;

  // Length after appending n bits, held at the word size.
  function automatic logic [LEN_W-1:0] add_len(input logic [LEN_W-1:0] len,
                                               input logic [SUM_W-1:0] n);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(len) + n;
    if (sum > SUM_W'(CODE_BITS)) begin
      sum = SUM_W'(CODE_BITS);
    end
    return LEN_W'(sum);
  endfunction

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_time_q <= BASE_TIME_RST;
      short_q     <= SHORT_RST;
      long_q      <= LONG_RST;
      sync_q      <= SYNC_RST;
      repeat_q    <= REPEAT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE_TIME: base_time_q <= cfg_data_i;
        REG_SHORT:     short_q     <= cfg_data_i[UNITS_W-1:0];
        REG_LONG:      long_q      <= cfg_data_i[UNITS_W-1:0];
        REG_SYNC:      sync_q      <= cfg_data_i[UNITS_W-1:0];
        REG_REPEAT:    repeat_q    <= cfg_data_i[REP_W-1:0];
        default: ;
      endcase
    end
  end

  // Code word assembled from the three selections of a start command.
  always_comb begin
    new_word = '0;
    new_len  = '0;
    if (s1_item_q.house_sel < 3'(HOUSE_COUNT)) begin
      new_word = (new_word << HOUSE_BITS) |
                 CODE_BITS'(HOUSE_PAT[s1_item_q.house_sel[1:0]]);
      new_len  = add_len(new_len, SUM_W'(HOUSE_BITS));
    end
    if (s1_item_q.unit_sel < 2'(UNIT_COUNT)) begin
      new_word = (new_word << UNIT_BITS) | CODE_BITS'(UNIT_PAT[s1_item_q.unit_sel]);
      new_len  = add_len(new_len, SUM_W'(UNIT_BITS));
    end
    if (s1_item_q.switch_sel == SW_OFF) begin
      new_word = (new_word << SW_BITS) | CODE_BITS'(SW_OFF_PAT);
      new_len  = add_len(new_len, SUM_W'(SW_BITS));
    end else if (s1_item_q.switch_sel == SW_ON) begin
      new_word = (new_word << SW_BITS) | CODE_BITS'(SW_ON_PAT);
      new_len  = add_len(new_len, SUM_W'(SW_BITS));
    end
  end

  // Bit being sent; bits go out from the most significant end.
  assign cur_idx = IDX_W'(bit_idx_q - LEN_W'(1));
  assign cur_bit = code_word_q[cur_idx];

  // Next segment and state for the item in the input stage.
  always_comb begin
    code_word_d = code_word_q;
    code_len_d  = code_len_q;
    bit_idx_d   = bit_idx_q;
    half_d      = half_q;
    frames_d    = frames_q;
    produce     = 1'b1;
    level       = 1'b1;
    fin         = 1'b0;
    units       = short_q;
    if (s1_item_q.cmd == CMD_START) begin
      code_word_d = new_word;
      code_len_d  = new_len;
      bit_idx_d   = new_len;
      half_d      = 1'b0;
      frames_d    = repeat_q;
    end else if (frames_q == '0) begin
      produce = 1'b0;
    end else if (bit_idx_q != '0) begin
      // Data bit: high half then low half.
      if (!half_q) begin
        half_d = 1'b1;
        units  = cur_bit ? long_q : short_q;
      end else begin
        half_d    = 1'b0;
        bit_idx_d = bit_idx_q - LEN_W'(1);
        level     = 1'b0;
        units     = cur_bit ? short_q : long_q;
      end
    end else begin
      // Sync: short high, then the long gap that closes the frame.
      if (!half_q) begin
        half_d = 1'b1;
      end else begin
        half_d    = 1'b0;
        bit_idx_d = code_len_q;
        frames_d  = frames_q - REP_W'(1);
        level     = 1'b0;
        units     = sync_q;
        fin       = (frames_q == REP_W'(1));
      end
    end
  end

  // Items without a result leave regardless of the result register.
  assign s1_adv   = s1_valid_q && (!produce || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      code_word_q <= '0;
      code_len_q  <= '0;
      bit_idx_q   <= '0;
      half_q      <= 1'b0;
      frames_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        code_word_q <= code_word_d;
        code_len_q  <= code_len_d;
        bit_idx_q   <= bit_idx_d;
        half_q      <= half_d;
        frames_q    <= frames_d;
      end
      if (s1_adv && produce) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_item_q <= in_i.data;
    end
    if (s1_adv && produce) begin
      out_item_q.pin_level     <= level;
      out_item_q.duration_us   <= DUR_W'(base_time_q) * DUR_W'(units);
      out_item_q.final_segment <= fin;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  // The send position never runs past the stored code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_idx_q <= code_len_q)
    else $error("bit index beyond code length");

  // The stored length never exceeds the word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_len_q <= LEN_W'(CODE_BITS))
    else $error("code length beyond word size");

  // An idle transmitter always waits at a high half.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q == '0 |-> !half_q)
    else $error("idle with half phase set");

  // A segment leaving the input stage lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && produce |=> out_valid_q)
    else $error("segment lost");

  // The final segment is always a low gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.final_segment |-> !out_item_q.pin_level)
    else $error("final segment not low");

endmodule

`default_nettype wire

// File: tb/sv/ookt_segment_checker.sv
// Watches the configuration port and both channels of the transmitter, keeps
// its own copy of the timing registers and the transmission state, and checks
// every result transfer against the oldest predicted pin segment.
module ookt_segment_checker import ookt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  // Shadow copy of the timing registers.
  logic [BASE_W-1:0]  base_time;
  logic [UNITS_W-1:0] short_len;
  logic [UNITS_W-1:0] long_len;
  logic [UNITS_W-1:0] sync_len;
  logic [REP_W-1:0]   repeat_len;

  // Shadow copy of the transmission state.
  logic [CODE_BITS-1:0] code_word;
  logic [LEN_W-1:0]     code_len;
  logic [5:0]           bits_left;
  logic                 low_half_next;
  logic [REP_W-1:0]     frames_left;

  out_item_t   segments_due[$];
  out_item_t   predicted;
  out_item_t   oldest;
  logic        has_segment;
  int unsigned mismatches;

  function automatic logic [DUR_W-1:0] segment_time(input logic [UNITS_W-1:0] units);
    return DUR_W'(base_time) * DUR_W'(units);
  endfunction

  // Shift a selection pattern into the code word; the length saturates.
  task automatic append_pattern(input logic [CODE_BITS-1:0] pat, input int unsigned n);
    code_word = (code_word << n) | pat;
    if (int'(code_len) + n > CODE_BITS) begin
      code_len = LEN_W'(CODE_BITS);
    end else begin
      code_len = code_len + LEN_W'(n);
    end
  endtask

  task automatic fill_segment(input logic level, input logic [UNITS_W-1:0] units,
                              input logic last);
    predicted.pin_level     = level;
    predicted.duration_us   = segment_time(units);
    predicted.final_segment = last;
    has_segment             = 1'b1;
  endtask

  // Advance the transmitter by one command and work out the segment it yields.
  task automatic predict_segment(input in_item_t item);
    logic cur_bit;
    has_segment = 1'b0;
    if (item.cmd == CMD_START) begin
      code_word = '0;
      code_len  = '0;
      if (item.house_sel < HOUSE_COUNT) begin
        append_pattern(CODE_BITS'(HOUSE_PAT[item.house_sel]), HOUSE_BITS);
      end
      if (item.unit_sel < UNIT_COUNT) begin
        append_pattern(CODE_BITS'(UNIT_PAT[item.unit_sel]), UNIT_BITS);
      end
      if (item.switch_sel == SW_OFF) begin
        append_pattern(CODE_BITS'(SW_OFF_PAT), SW_BITS);
      end else if (item.switch_sel == SW_ON) begin
        append_pattern(CODE_BITS'(SW_ON_PAT), SW_BITS);
      end
      bits_left     = 6'(code_len);
      low_half_next = 1'b0;
      frames_left   = repeat_len;
      fill_segment(1'b1, short_len, 1'b0);
    end else if (frames_left == '0) begin
      // Idle expiry: nothing to send.
    end else if (bits_left != '0) begin
      cur_bit = code_word[bits_left - 6'd1];
      if (!low_half_next) begin
        low_half_next = 1'b1;
        fill_segment(1'b1, cur_bit ? long_len : short_len, 1'b0);
      end else begin
        low_half_next = 1'b0;
        bits_left     = bits_left - 6'd1;
        fill_segment(1'b0, cur_bit ? short_len : long_len, 1'b0);
      end
    end else if (!low_half_next) begin
      low_half_next = 1'b1;
      fill_segment(1'b1, short_len, 1'b0);
    end else begin
      low_half_next = 1'b0;
      bits_left     = 6'(code_len);
      frames_left   = frames_left - 1'b1;
      fill_segment(1'b0, sync_len, frames_left == '0);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_time     = BASE_TIME_RST;
      short_len     = SHORT_RST;
      long_len      = LONG_RST;
      sync_len      = SYNC_RST;
      repeat_len    = REPEAT_RST;
      code_word     = '0;
      code_len      = '0;
      bits_left     = '0;
      low_half_next = 1'b0;
      frames_left   = '0;
      mismatches    = 0;
      segments_due.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Register writes land before any command seen at the same edge.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BASE_TIME: base_time  = cfg_data_i[BASE_W-1:0];
          REG_SHORT:     short_len  = cfg_data_i[UNITS_W-1:0];
          REG_LONG:      long_len   = cfg_data_i[UNITS_W-1:0];
          REG_SYNC:      sync_len   = cfg_data_i[UNITS_W-1:0];
          REG_REPEAT:    repeat_len = cfg_data_i[REP_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        predict_segment(in_data_i);
        if (has_segment) begin
          segments_due.push_back(predicted);
        end
      end

      // Compare each result transfer with the oldest outstanding segment.
      if (out_valid_i && out_ready_i) begin
        if (segments_due.size() == 0) begin
          report_mismatch($sformatf("segment with none outstanding: level %0d dur %0d fin %0d",
                                    out_data_i.pin_level, out_data_i.duration_us,
                                    out_data_i.final_segment));
        end else begin
          oldest = segments_due.pop_front();
          if (out_data_i.pin_level !== oldest.pin_level) begin
            report_mismatch($sformatf("pin_level got %0d want %0d",
                                      out_data_i.pin_level, oldest.pin_level));
          end
          if (out_data_i.duration_us !== oldest.duration_us) begin
            report_mismatch($sformatf("duration_us got %0d want %0d",
                                      out_data_i.duration_us, oldest.duration_us));
          end
          if (out_data_i.final_segment !== oldest.final_segment) begin
            report_mismatch($sformatf("final_segment got %0d want %0d",
                                      out_data_i.final_segment, oldest.final_segment));
          end
        end
      end

      pending_o    <= segments_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: tb/sv/tb_ook_remote_code_transmitter_top.sv
// Drives start and timer-expiry commands into the transmitter under a range
// of timing settings, with random gaps on the command side and random stalls
// on the segment side; the checker beside the block predicts and compares.
module tb_ook_remote_code_transmitter_top;
  import ookt_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int SETTLE_CYCLES = 8;
  localparam longint TIMEOUT = 64'd12 * 64'd1_200_000;
  // An index past the register list; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           fail_count;
  int unsigned           pending;

  // Stimulus bookkeeping.
  bit          calm;
  int          out_stall;
  int unsigned cur_repeat;
  int unsigned sent_items;

  ookt_in_if  in_ch ();
  ookt_out_if out_ch ();

  ook_remote_code_transmitter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  ookt_segment_checker segment_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Register values: range ends, zero, full width, or anything in range.
  function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi,
                                             input int unsigned full);
    int r;
    r = $urandom_range(0, 19);
    if (r < 4) return lo;
    if (r < 8) return hi;
    if (r == 8) return 0;
    if (r == 9) return full;
    return $urandom_range(lo, hi);
  endfunction

  // Segment side: random stalls unless in a calm stretch.
  initial begin
    out_ch.ready = 1'b0;
    out_stall    = 0;
    forever begin
      @(posedge clk_i);
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall    <= out_stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) begin
          out_stall <= pick_gap();
        end
      end
    end
  end

  // One command transfer; valid stays high so back-to-back items need no drop.
  task automatic send_item(input in_item_t item);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_start(input logic [2:0] house, input logic [1:0] unit,
                            input logic [1:0] sw);
    in_item_t item;
    item.cmd        = CMD_START;
    item.house_sel  = house;
    item.unit_sel   = unit;
    item.switch_sel = sw;
    send_item(item);
  endtask

  // Expiries carry random selection bits, which the block ignores.
  task automatic send_expiry();
    in_item_t item;
    item.cmd        = CMD_EXPIRY;
    item.house_sel  = 3'($urandom);
    item.unit_sel   = 2'($urandom);
    item.switch_sel = 2'($urandom);
    send_item(item);
  endtask

  // Hold the sender until every predicted segment has been seen.
  task automatic hold_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Full drain plus a settling wait for expiries that make no segment.
  task automatic drain_and_settle();
    hold_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  // Write all five registers; unused upper data bits carry noise.
  task automatic apply_setting(input int unsigned base, input int unsigned short_u,
                               input int unsigned long_u, input int unsigned sync_u,
                               input int unsigned rep);
    write_reg(REG_BASE_TIME, CFG_DATA_W'(base));
    write_reg(REG_SHORT, {2'($urandom), UNITS_W'(short_u)});
    write_reg(REG_LONG, {2'($urandom), UNITS_W'(long_u)});
    write_reg(REG_SYNC, {2'($urandom), UNITS_W'(sync_u)});
    write_reg(REG_REPEAT, {6'($urandom), REP_W'(rep)});
    cfg_we     <= 1'b0;
    cur_repeat  = rep;
  endtask

  task automatic random_setting();
    int unsigned rep;
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) rep = 0;
    else if (r == 1) rep = 15;
    else if (r < 14) rep = $urandom_range(1, 2);
    else rep = $urandom_range(3, 5);
    apply_setting(pick_value(1, 1000, 1023), pick_value(1, 255, 255),
                  pick_value(1, 255, 255), pick_value(1, 255, 255), rep);
  endtask

  // A start followed by expiries; most run the whole transmission, some are cut
  // short by the next start, and finished ones may get a few idle expiries.
  task automatic run_transmission();
    logic [2:0]  house;
    logic [1:0]  unit;
    logic [1:0]  sw;
    int unsigned code_bits;
    int unsigned full_len;
    int unsigned count;
    house = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(4, 7));
    unit  = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, 2)) : 2'd3;
    sw    = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
    code_bits = (house < HOUSE_COUNT ? HOUSE_BITS : 0) + (unit < UNIT_COUNT ? UNIT_BITS : 0) +
                (sw <= SW_ON ? SW_BITS : 0);
    full_len  = (cur_repeat == 0) ? 2 : cur_repeat * (2 * code_bits + 2);
    count     = full_len;
    if ($urandom_range(0, 4) == 0) count = $urandom_range(0, full_len);
    if (count > 200) count = $urandom_range(100, 200);
    if ($urandom_range(0, 9) == 0) hold_for_drain();
    send_start(house, unit, sw);
    repeat (count) send_expiry();
    sent_items += 1 + count;
    if (count == full_len) begin
      repeat ($urandom_range(0, 2)) send_expiry();
    end
  endtask

  // Command timeout guard.
  initial begin
    #(TIMEOUT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    calm        = 1'b0;
    cur_repeat  = REPEAT_RST;
    sent_items  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: idle expiry, then an empty code sent to its last frame.
    send_expiry();
    send_start(3'd4, 2'd3, 2'd2);
    repeat (2 * REPEAT_RST) send_expiry();
    send_expiry();

    // Unused register index, then zero base time and short length and a zero
    // repeat count.
    drain_and_settle();
    write_reg(REG_UNUSED, 10'h3FF);
    apply_setting(0, 0, 255, 1, 0);
    send_start(3'd3, 2'd2, 2'd1);
    repeat (2) send_expiry();

    // Largest base time, short and sync lengths with the smallest long length; a unit-only code cut short by a restart.
    drain_and_settle();
    apply_setting(1023, 255, 1, 255, 1);
    send_start(3'd7, 2'd0, 2'd3);
    repeat (6) send_expiry();
    send_start(3'd0, 2'd3, 2'd0);
    repeat (2) send_expiry();

    // Random phases, each under a fresh setting.
    while (sent_items < RANDOM_ITEMS) begin
      drain_and_settle();
      calm = ($urandom_range(0, 3) == 0);
      random_setting();
      repeat ($urandom_range(2, 5)) run_transmission();
    end

    drain_and_settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
design/ookt_pkg.sv
design/ookt_in_if.sv
design/ookt_out_if.sv
design/ook_remote_code_transmitter_top.sv
tb/sv/ookt_segment_checker.sv
tb/sv/tb_ook_remote_code_transmitter_top.sv
